// ----- rtl/mavq_pkg.sv -----
package mavq_pkg;

   // Window and sample geometry
   localparam int WINDOW_LOG2 = 7;
   localparam int WINDOW_LEN  = 1 << WINDOW_LOG2;
   localparam int POS_W       = WINDOW_LOG2;
   localparam int SAMPLE_W    = 20;
   localparam int SUM_W       = SAMPLE_W + WINDOW_LOG2;
   localparam int DIFF_W      = SAMPLE_W + 1;

   // Configuration register widths
   localparam int THRESH_W    = 20;
   localparam int OFFSET_W    = 20;
   localparam int SCALE_W     = 16;
   localparam int SHIFT_W     = 5;
   localparam int CSR_DATA_W  = 20;
   localparam int CSR_INDEX_W = 2;

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1000);
   localparam logic [SCALE_W-1:0]  SCALE_RESET  = SCALE_W'(1);

   // Millivolt conversion
   localparam int PROD_W = DIFF_W + SCALE_W + 1;
   localparam int MV_W   = 16;
   localparam int MV_MAX = (1 << (MV_W - 1)) - 1;
   localparam int MV_MIN = -(1 << (MV_W - 1));

   // Note quantization: round to nearest step, clamp to NOTE_STEPS
   localparam int NOTE_STEPS    = 60;
   localparam int FULL_SCALE_MV = 5000;
   localparam int STEP_MV       = FULL_SCALE_MV / NOTE_STEPS;
   localparam int ROUND_BIAS    = STEP_MV - STEP_MV / 2;
   localparam int CLAMP_MV      = NOTE_STEPS * STEP_MV - ROUND_BIAS;
   localparam int NOTE_W        = $clog2(NOTE_STEPS + 1);
   localparam int ROUND_W       = 13;
   localparam int RECIP_SHIFT   = 25;
   localparam int RECIP         = ((1 << RECIP_SHIFT) + STEP_MV - 1) / STEP_MV;
   localparam int RECIP_W       = $clog2(RECIP + 1);
   localparam int QPROD_W       = ROUND_W + RECIP_W;
   localparam int PWM_W         = 13;
   localparam int ROM_DEPTH     = 1 << NOTE_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLOPE_THRESHOLD = 2'd0,
      CSR_COUNT_OFFSET    = 2'd1,
      CSR_MV_SCALE        = 2'd2,
      CSR_MV_SHIFT        = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [OFFSET_W-1:0] count_offset;
      logic [SCALE_W-1:0]         mv_scale;
      logic [SHIFT_W-1:0]         mv_shift;
   } conv_cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] average;
      logic                       refilled;
   } win_out_type;

   // Lowest member last, so the struct packs straight into tdata
   typedef struct packed {
      logic                       filter_refilled;
      logic                       step_changed;
      logic [PWM_W-1:0]           pwm_compare;
      logic [NOTE_W-1:0]          note_step;
      logic signed [MV_W-1:0]     millivolts;
      logic signed [SAMPLE_W-1:0] average_counts;
   } result_type;

   localparam int RESULT_W   = $bits(result_type);
   localparam int RSP_DATA_W = ((RESULT_W + 7) / 8) * 8;
   localparam int REQ_DATA_W = ((SAMPLE_W + 7) / 8) * 8;

   typedef logic [PWM_W-1:0] pwm_rom_type [ROM_DEPTH];

   function automatic pwm_rom_type build_pwm_rom();
      pwm_rom_type rom;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         if (i <= NOTE_STEPS) begin
            rom[i] = PWM_W'((i * 2 * FULL_SCALE_MV / NOTE_STEPS + 1) / 2);
         end else begin
            rom[i] = '0;
         end
      end
      return rom;
   endfunction

   localparam pwm_rom_type PWM_ROM = build_pwm_rom();

endpackage

// ----- rtl/mavq_ram.sv -----
module mavq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mavq_window.sv -----
module mavq_window
   import mavq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic [THRESH_W-1:0]        slope_threshold,
   output logic                       out_valid,
   input  logic                       out_ready,
   output win_out_type                out_data
);

   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [WINDOW_LEN-1:0]      stale_ff, stale_in;
   logic                       primed_ff, primed_in;
   logic                       valid_ff, valid_in;
   logic                       refill_ff, refill_in;

   logic                       accept;
   logic                       refill;
   logic signed [DIFF_W-1:0]   diff;
   logic [DIFF_W-1:0]          mag;
   logic signed [SAMPLE_W-1:0] oldest;
   logic [SAMPLE_W-1:0]        rd_data;
   logic                       wr_en;
   logic signed [SAMPLE_W-1:0] average;

   // Read address follows the next position, so the oldest entry is already
   // registered when the following sample arrives. Write goes to the current
   // position, which never equals the read address.
   mavq_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW_LEN)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff),
      .wr_data (sample),
      .rd_addr (pos_in),
      .rd_data (rd_data)
   );

   assign average = sum_ff[SUM_W-1:WINDOW_LOG2];

   always_comb begin
      in_ready  = !valid_ff || out_ready;
      accept    = in_valid && in_ready;
      diff      = DIFF_W'(average) - DIFF_W'(sample);
      mag       = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      refill    = !primed_ff || (mag > DIFF_W'(slope_threshold));
      oldest    = stale_ff[pos_ff] ? fill_ff : signed'(rd_data);

      sum_in    = sum_ff;
      fill_in   = fill_ff;
      pos_in    = pos_ff;
      stale_in  = stale_ff;
      primed_in = primed_ff;
      valid_in  = valid_ff;
      refill_in = refill_ff;
      wr_en     = 1'b0;

      if (in_ready) begin
         valid_in = in_valid;
      end
      if (accept) begin
         refill_in = refill;
         if (refill) begin
            stale_in  = '1;
            fill_in   = sample;
            sum_in    = {sample, {WINDOW_LOG2{1'b0}}};
            pos_in    = '0;
            primed_in = 1'b1;
         end else begin
            sum_in           = sum_ff - SUM_W'(oldest) + SUM_W'(sample);
            stale_in[pos_ff] = 1'b0;
            pos_in           = pos_ff + 1'b1;
            wr_en            = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         pos_ff    <= '0;
         stale_ff  <= '1;
         primed_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         sum_ff    <= sum_in;
         pos_ff    <= pos_in;
         stale_ff  <= stale_in;
         primed_ff <= primed_in;
         valid_ff  <= valid_in;
      end
      fill_ff   <= fill_in;
      refill_ff <= refill_in;
   end

   assign out_valid         = valid_ff;
   assign out_data.average  = average;
   assign out_data.refilled = refill_ff;

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> pos_ff != pos_in)
      else $error("window RAM read and write hit the same entry");

   a_refill_restart: assert property (@(posedge clock) disable iff (reset)
      accept && refill |=> pos_ff == '0 && stale_ff == '1 && primed_ff)
      else $error("refill did not restart the window");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(sum_ff))
      else $error("window state moved while its result was stalled");

endmodule

// ----- rtl/mavq_convert.sv -----
module mavq_convert
   import mavq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  conv_cfg_type cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  win_out_type  in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output result_type   out_data
);

   // a: offset removed, b: scaled, c: shifted and saturated,
   // d: note step, e: output register with ROM lookup
   logic                       a_valid_ff, a_valid_in;
   logic signed [DIFF_W-1:0]   a_diff_ff, a_diff_in;
   logic signed [SAMPLE_W-1:0] a_avg_ff, a_avg_in;
   logic                       a_ref_ff, a_ref_in;

   logic                       b_valid_ff, b_valid_in;
   logic signed [PROD_W-1:0]   b_prod_ff, b_prod_in;
   logic signed [SAMPLE_W-1:0] b_avg_ff, b_avg_in;
   logic                       b_ref_ff, b_ref_in;

   logic                       c_valid_ff, c_valid_in;
   logic signed [MV_W-1:0]     c_mv_ff, c_mv_in;
   logic signed [SAMPLE_W-1:0] c_avg_ff, c_avg_in;
   logic                       c_ref_ff, c_ref_in;

   logic                       d_valid_ff, d_valid_in;
   logic [NOTE_W-1:0]          d_step_ff, d_step_in;
   logic signed [MV_W-1:0]     d_mv_ff, d_mv_in;
   logic signed [SAMPLE_W-1:0] d_avg_ff, d_avg_in;
   logic                       d_ref_ff, d_ref_in;

   logic                       e_valid_ff, e_valid_in;
   result_type                 e_res_ff, e_res_in;
   logic [NOTE_W-1:0]          prev_step_ff, prev_step_in;

   logic                       a_ready, b_ready, c_ready, d_ready, e_ready;
   logic signed [SCALE_W:0]    scale_s;
   logic signed [PROD_W-1:0]   shifted;
   logic [ROUND_W-1:0]         round_x;
   logic [QPROD_W-1:0]         qprod;

   always_comb begin
      e_ready  = !e_valid_ff || out_ready;
      d_ready  = !d_valid_ff || e_ready;
      c_ready  = !c_valid_ff || d_ready;
      b_ready  = !b_valid_ff || c_ready;
      a_ready  = !a_valid_ff || b_ready;
      in_ready = a_ready;

      scale_s = signed'({1'b0, cfg.mv_scale});
      shifted = b_prod_ff >>> cfg.mv_shift;
      round_x = c_mv_ff[ROUND_W-1:0] + ROUND_W'(ROUND_BIAS);
      qprod   = QPROD_W'(round_x) * QPROD_W'(RECIP);

      a_valid_in = a_valid_ff;  a_diff_in = a_diff_ff;  a_avg_in = a_avg_ff;
      a_ref_in   = a_ref_ff;
      b_valid_in = b_valid_ff;  b_prod_in = b_prod_ff;  b_avg_in = b_avg_ff;
      b_ref_in   = b_ref_ff;
      c_valid_in = c_valid_ff;  c_mv_in   = c_mv_ff;    c_avg_in = c_avg_ff;
      c_ref_in   = c_ref_ff;
      d_valid_in = d_valid_ff;  d_step_in = d_step_ff;  d_mv_in  = d_mv_ff;
      d_avg_in   = d_avg_ff;    d_ref_in  = d_ref_ff;
      e_valid_in = e_valid_ff;  e_res_in  = e_res_ff;
      prev_step_in = prev_step_ff;

      if (a_ready) begin
         a_valid_in = in_valid;
         if (in_valid) begin
            a_diff_in = DIFF_W'(in_data.average) - DIFF_W'(cfg.count_offset);
            a_avg_in  = in_data.average;
            a_ref_in  = in_data.refilled;
         end
      end

      if (b_ready) begin
         b_valid_in = a_valid_ff;
         if (a_valid_ff) begin
            b_prod_in = a_diff_ff * scale_s;
            b_avg_in  = a_avg_ff;
            b_ref_in  = a_ref_ff;
         end
      end

      if (c_ready) begin
         c_valid_in = b_valid_ff;
         if (b_valid_ff) begin
            if (shifted > signed'(PROD_W'(MV_MAX))) begin
               c_mv_in = MV_W'(MV_MAX);
            end else if (shifted < signed'(PROD_W'(MV_MIN))) begin
               c_mv_in = MV_W'(MV_MIN);
            end else begin
               c_mv_in = shifted[MV_W-1:0];
            end
            c_avg_in = b_avg_ff;
            c_ref_in = b_ref_ff;
         end
      end

      if (d_ready) begin
         d_valid_in = c_valid_ff;
         if (c_valid_ff) begin
            // floor((mv + bias) / step) by reciprocal; exact below the clamp point
            if (c_mv_ff[MV_W-1]) begin
               d_step_in = '0;
            end else if (c_mv_ff[MV_W-2:0] >= (MV_W-1)'(CLAMP_MV)) begin
               d_step_in = NOTE_W'(NOTE_STEPS);
            end else begin
               d_step_in = qprod[RECIP_SHIFT +: NOTE_W];
            end
            d_mv_in  = c_mv_ff;
            d_avg_in = c_avg_ff;
            d_ref_in = c_ref_ff;
         end
      end

      if (e_ready) begin
         e_valid_in = d_valid_ff;
         if (d_valid_ff) begin
            e_res_in.average_counts  = d_avg_ff;
            e_res_in.millivolts      = d_mv_ff;
            e_res_in.note_step       = d_step_ff;
            e_res_in.pwm_compare     = PWM_ROM[d_step_ff];
            e_res_in.step_changed    = d_step_ff != prev_step_ff;
            e_res_in.filter_refilled = d_ref_ff;
            prev_step_in             = d_step_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         prev_step_ff <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         d_valid_ff   <= d_valid_in;
         e_valid_ff   <= e_valid_in;
         prev_step_ff <= prev_step_in;
      end
      a_diff_ff <= a_diff_in;  a_avg_ff <= a_avg_in;  a_ref_ff <= a_ref_in;
      b_prod_ff <= b_prod_in;  b_avg_ff <= b_avg_in;  b_ref_ff <= b_ref_in;
      c_mv_ff   <= c_mv_in;    c_avg_ff <= c_avg_in;  c_ref_ff <= c_ref_in;
      d_step_ff <= d_step_in;  d_mv_ff  <= d_mv_in;   d_avg_ff <= d_avg_in;
      d_ref_ff  <= d_ref_in;
      e_res_ff  <= e_res_in;
   end

   assign out_valid = e_valid_ff;
   assign out_data  = e_res_ff;

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      d_valid_ff |-> d_step_ff <= NOTE_W'(NOTE_STEPS))
      else $error("note step above top step");

   a_prev_tracks_out: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff |-> e_res_ff.note_step == prev_step_ff)
      else $error("previous step out of line with the presented result");

   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      out_ready |-> in_ready)
      else $error("pipeline blocks input while the output drains");

endmodule

// ----- rtl/moving_average_note_quantizer.sv -----
// Channel   Direction  Ports        Payload
// req       in         req_t*       sample
// rsp       out        rsp_t*       average_counts, millivolts, note_step, pwm_compare,
//                                   step_changed, filter_refilled
// csr       in         csr_*        slope_threshold, count_offset, mv_scale, mv_shift
//
// One sample per cycle while the rsp channel is not stalled; the window register and stages
// a to e of the conversion lie between a req transaction and its matching rsp transaction.
// Throughput is set by the window update: the oldest entry is read ahead into the RAM output
// register from the next position, then subtracted and the new sample added as it is accepted.
// Synchronous reset; no clearing pass, stale bits in flops cover the whole window.
// A stalled rsp channel holds each stage that is full; empty stages still fill.
module moving_average_note_quantizer
   import mavq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [19:0] sample
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [19:0] average_counts, [35:20] millivolts,
                                               // [41:36] note_step, [54:42] pwm_compare,
                                               // [55] step_changed, [56] filter_refilled
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [THRESH_W-1:0]        thresh_ff, thresh_in;
   logic signed [OFFSET_W-1:0] offset_ff, offset_in;
   logic [SCALE_W-1:0]         scale_ff, scale_in;
   logic [SHIFT_W-1:0]         shift_ff, shift_in;

   conv_cfg_type cfg;
   win_out_type  win_data;
   logic         win_valid;
   logic         win_ready;
   result_type   result;

   always_comb begin
      thresh_in = thresh_ff;
      offset_in = offset_ff;
      scale_in  = scale_ff;
      shift_in  = shift_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SLOPE_THRESHOLD: thresh_in = csr_wdata[THRESH_W-1:0];
            CSR_COUNT_OFFSET:    offset_in = signed'(csr_wdata[OFFSET_W-1:0]);
            CSR_MV_SCALE:        scale_in  = csr_wdata[SCALE_W-1:0];
            CSR_MV_SHIFT:        shift_in  = csr_wdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         offset_ff <= '0;
         scale_ff  <= SCALE_RESET;
         shift_ff  <= '0;
      end else begin
         thresh_ff <= thresh_in;
         offset_ff <= offset_in;
         scale_ff  <= scale_in;
         shift_ff  <= shift_in;
      end
   end

   assign cfg.count_offset = offset_ff;
   assign cfg.mv_scale     = scale_ff;
   assign cfg.mv_shift     = shift_ff;

   mavq_window u_window (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .sample          (signed'(req_tdata[SAMPLE_W-1:0])),
      .slope_threshold (thresh_ff),
      .out_valid       (win_valid),
      .out_ready       (win_ready),
      .out_data        (win_data)
   );

   mavq_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (win_valid),
      .in_ready  (win_ready),
      .in_data   (win_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (result)
   );

   assign rsp_tdata = {{(RSP_DATA_W-RESULT_W){1'b0}}, result};

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
   import mavq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 6;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 142;
   localparam int SAMPLE_MAX  = (1 << (SAMPLE_W - 1)) - 1;
   localparam int SAMPLE_MIN  = -(1 << (SAMPLE_W - 1));

   typedef enum bit {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      csr_index_type index;
      int            value;
      bit            typed;
      result_type    want;
   } dir_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Shadow of the block: configuration and window state
   logic [THRESH_W-1:0]        thresh_reg;
   logic signed [OFFSET_W-1:0] offset_reg;
   logic [SCALE_W-1:0]         scale_reg;
   logic [SHIFT_W-1:0]         shift_reg;
   logic signed [SAMPLE_W-1:0] window_mem [WINDOW_LEN];
   bit                         stale_mark [WINDOW_LEN];
   logic signed [SAMPLE_W-1:0] fill_sample;
   longint                     window_sum;
   logic [POS_W-1:0]           window_pos;
   logic signed [SAMPLE_W-1:0] avg_now;
   bit                         primed;
   int                         prev_step;

   result_type notes_due [$];
   int         mismatch_count;
   int         idle_pct;
   int         cycle_count;

   moving_average_note_quantizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic result_type quantize_sample(logic signed [SAMPLE_W-1:0] s);
      result_type                 r;
      longint                     jump;
      longint                     mv;
      logic signed [SAMPLE_W-1:0] oldest;
      logic [POS_W-1:0]           p;
      bit                         refill;
      int                         q;
      int                         rem;
      int                         step;
      jump = longint'(avg_now) - longint'(s);
      if (jump < 0) jump = -jump;
      refill = !primed || jump > longint'(thresh_reg);
      if (refill) begin
         foreach (stale_mark[i]) stale_mark[i] = 1'b1;
         fill_sample = s;
         window_sum  = longint'(s) * WINDOW_LEN;
         avg_now     = s;
         window_pos  = '0;
         primed      = 1'b1;
      end else begin
         p = window_pos;
         oldest = stale_mark[p] ? fill_sample : window_mem[p];
         window_sum = window_sum - longint'(oldest) + longint'(s);
         avg_now = SAMPLE_W'(window_sum >>> WINDOW_LOG2);
         window_mem[p] = s;
         stale_mark[p] = 1'b0;
         window_pos = p + 1'b1;
      end
      // floor shift, then saturate to 16 bits
      mv = ((longint'(avg_now) - longint'(offset_reg)) * longint'(scale_reg)) >>> shift_reg;
      if (mv > MV_MAX) mv = MV_MAX;
      if (mv < MV_MIN) mv = MV_MIN;
      if (mv < 0) begin
         step = 0;
      end else begin
         q = int'(mv) / STEP_MV;
         rem = int'(mv) % STEP_MV;
         if (rem >= STEP_MV / 2) q++;
         step = (q > NOTE_STEPS) ? NOTE_STEPS : q;
      end
      r.average_counts  = avg_now;
      r.millivolts      = MV_W'(mv);
      r.note_step       = NOTE_W'(step);
      r.pwm_compare     = PWM_W'((step * 2 * FULL_SCALE_MV / NOTE_STEPS + 1) / 2);
      r.step_changed    = (step != prev_step);
      r.filter_refilled = refill;
      prev_step = step;
      return r;
   endfunction

   function automatic result_type note_result(int avg, int mv, int step, int pwm,
                                              bit changed, bit refilled);
      result_type r;
      r.average_counts  = SAMPLE_W'(avg);
      r.millivolts      = MV_W'(mv);
      r.note_step       = NOTE_W'(step);
      r.pwm_compare     = PWM_W'(pwm);
      r.step_changed    = changed;
      r.filter_refilled = refilled;
      return r;
   endfunction

   function automatic dir_row_type sample_row(int value, bit typed = 1'b0,
                                              result_type want = '0);
      dir_row_type row;
      row.kind  = ROW_SAMPLE;
      row.index = CSR_SLOPE_THRESHOLD;
      row.value = value;
      row.typed = typed;
      row.want  = want;
      return row;
   endfunction

   function automatic dir_row_type csr_row(csr_index_type idx, int value);
      dir_row_type row;
      row.kind  = ROW_CSR;
      row.index = idx;
      row.value = value;
      row.typed = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   task automatic send_sample(int value, bit typed, result_type want);
      result_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - SAMPLE_W){1'b0}}, value[SAMPLE_W-1:0]};
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = quantize_sample(value[SAMPLE_W-1:0]);
      notes_due.push_back(typed ? want : predicted);
   endtask

   // Quiet the input side and wait until the pipeline has emptied
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (notes_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SLOPE_THRESHOLD: thresh_reg = value[THRESH_W-1:0];
         CSR_COUNT_OFFSET:    offset_reg = value[OFFSET_W-1:0];
         CSR_MV_SCALE:        scale_reg  = value[SCALE_W-1:0];
         CSR_MV_SHIFT:        shift_reg  = value[SHIFT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Result side: random stalls, check every transaction in order
   initial begin
      result_type got;
      result_type exp;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            got = result_type'(rsp_tdata[RESULT_W-1:0]);
            if (notes_due.size() == 0) begin
               $error("result transaction with nothing outstanding: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               exp = notes_due.pop_front();
               if (got.average_counts !== exp.average_counts) begin
                  $error("average_counts: expected %0d, got %0d",
                         exp.average_counts, got.average_counts);
                  mismatch_count++;
               end
               if (got.millivolts !== exp.millivolts) begin
                  $error("millivolts: expected %0d, got %0d", exp.millivolts, got.millivolts);
                  mismatch_count++;
               end
               if (got.note_step !== exp.note_step) begin
                  $error("note_step: expected %0d, got %0d", exp.note_step, got.note_step);
                  mismatch_count++;
               end
               if (got.pwm_compare !== exp.pwm_compare) begin
                  $error("pwm_compare: expected %0d, got %0d",
                         exp.pwm_compare, got.pwm_compare);
                  mismatch_count++;
               end
               if (got.step_changed !== exp.step_changed) begin
                  $error("step_changed: expected %0b, got %0b",
                         exp.step_changed, got.step_changed);
                  mismatch_count++;
               end
               if (got.filter_refilled !== exp.filter_refilled) begin
                  $error("filter_refilled: expected %0b, got %0b",
                         exp.filter_refilled, got.filter_refilled);
                  mismatch_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      dir_row_type directed_rows [30];
      int          thr;
      int          off;
      int          scl;
      int          sh;
      int          lim;
      int          roll;
      int          s;
      int          center;
      directed_rows = '{
         sample_row(0,          1'b1, note_result(0, 0, 0, 0, 1'b0, 1'b1)),
         sample_row(100,        1'b1, note_result(0, 0, 0, 0, 1'b0, 1'b0)),
         sample_row(SAMPLE_MAX, 1'b1,
                    note_result(SAMPLE_MAX, MV_MAX, NOTE_STEPS, FULL_SCALE_MV, 1'b1, 1'b1)),
         sample_row(SAMPLE_MIN, 1'b1, note_result(SAMPLE_MIN, MV_MIN, 0, 0, 1'b1, 1'b1)),
         sample_row(SAMPLE_MIN, 1'b1, note_result(SAMPLE_MIN, MV_MIN, 0, 0, 1'b0, 1'b0)),
         // half a step rounds up, one count less rounds down
         sample_row(41,         1'b1, note_result(41, 41, 1, 83, 1'b1, 1'b1)),
         sample_row(40,         1'b1, note_result(40, 40, 0, 0, 1'b1, 1'b0)),
         csr_row(CSR_SLOPE_THRESHOLD, 0),
         sample_row(40),
         sample_row(39,         1'b1, note_result(39, 39, 0, 0, 1'b0, 1'b1)),
         csr_row(CSR_SLOPE_THRESHOLD, (1 << THRESH_W) - 1),
         sample_row(SAMPLE_MAX),
         sample_row(SAMPLE_MIN),
         csr_row(CSR_MV_SCALE, (1 << SCALE_W) - 1),
         csr_row(CSR_COUNT_OFFSET, SAMPLE_MIN),
         sample_row(4938),
         csr_row(CSR_MV_SCALE, 1),
         csr_row(CSR_COUNT_OFFSET, 0),
         csr_row(CSR_SLOPE_THRESHOLD, 0),
         // around and above the top step
         sample_row(4938),
         sample_row(4979),
         sample_row(5100),
         sample_row(83),
         csr_row(CSR_MV_SHIFT, (1 << SHIFT_W) - 1),
         sample_row(-1000),
         csr_row(CSR_MV_SHIFT, 0),
         csr_row(CSR_COUNT_OFFSET, SAMPLE_MAX),
         sample_row(0),
         csr_row(CSR_COUNT_OFFSET, 0),
         csr_row(CSR_SLOPE_THRESHOLD, 1000)
      };

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_SLOPE_THRESHOLD;
      csr_wdata  <= '0;
      idle_pct       = 37;
      mismatch_count = 0;
      thresh_reg     = THRESH_RESET;
      offset_reg     = '0;
      scale_reg      = SCALE_RESET;
      shift_reg      = '0;
      foreach (stale_mark[i]) stale_mark[i] = 1'b1;
      fill_sample = '0;
      window_sum  = 0;
      window_pos  = '0;
      avg_now     = '0;
      primed      = 1'b0;
      prev_step   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            settle();
            csr_write(directed_rows[i].index, directed_rows[i].value);
         end else begin
            send_sample(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         if (ph == 0) begin
            thr = 1000; off = 0; scl = 1; sh = 0;
         end else if (ph == 1) begin
            thr = 0; off = SAMPLE_MIN; scl = 0; sh = 0;
         end else if (ph == 2) begin
            thr = (1 << THRESH_W) - 1; off = SAMPLE_MAX;
            scl = (1 << SCALE_W) - 1; sh = (1 << SHIFT_W) - 1;
         end else if (ph % 3 == 0) begin
            // small offset, scale and shift with a moderate slope threshold
            thr = $urandom_range(3000, 50);
            off = int'($urandom_range(400)) - 200;
            scl = $urandom_range(4, 1);
            sh  = $urandom_range(2);
         end else begin
            thr = $urandom_range(1) ? $urandom_range((1 << THRESH_W) - 1) : $urandom_range(5000);
            off = int'($urandom_range((1 << OFFSET_W) - 1)) + SAMPLE_MIN;
            scl = $urandom_range((1 << SCALE_W) - 1);
            sh  = $urandom_range((1 << SHIFT_W) - 1);
         end
         csr_write(CSR_SLOPE_THRESHOLD, thr);
         csr_write(CSR_COUNT_OFFSET, off);
         csr_write(CSR_MV_SCALE, scl);
         csr_write(CSR_MV_SHIFT, sh);
         // first phase runs back to back on both sides
         idle_pct = (ph == 0) ? 0 : 37;
         center = int'($urandom_range(5600)) - 300;
         lim = (thr > 2000) ? 2000 : thr;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == 4 && k == PHASE_ITEMS / 2) settle();
            roll = $urandom_range(99);
            if (roll < 70) begin
               s = int'(avg_now) + int'($urandom_range(2 * lim)) - lim;
            end else if (roll < 85) begin
               s = center + int'($urandom_range(600)) - 300;
            end else if (roll < 95) begin
               s = int'($urandom_range((1 << SAMPLE_W) - 1)) + SAMPLE_MIN;
            end else begin
               s = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
            end
            if (s > SAMPLE_MAX) s = SAMPLE_MAX;
            if (s < SAMPLE_MIN) s = SAMPLE_MIN;
            send_sample(s, 1'b0, '0);
         end
      end

      idle_pct = 37;
      settle();
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
